/* sv/utf8_to_utf16_decoder_defines.svh */
// Assertion macros for the UTF-8 to UTF-16 decoder.
// No dependencies; taken in by `include in the files that assert.
`ifndef UTF8_TO_UTF16_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, disabled while reset is held
`define U8U16_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define U8U16_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U8U16_ASSERT(lbl, clk, rst_n, prop, msg)
`define U8U16_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* sv/u8u16_pkg.sv */
// Types, constants and helper functions of the UTF-8 to UTF-16 decoder.
// No dependencies.
package u8u16_pkg;

    localparam int ACC_W = 31;

    localparam logic [ACC_W-1:0] MAX_SCALAR = 31'h0010_FFFF;
    localparam logic [ACC_W-1:0] SURR_LO    = 31'h0000_D800;
    localparam logic [ACC_W-1:0] SURR_HI    = 31'h0000_DFFF;
    localparam logic [ACC_W-1:0] SUPP_BASE  = 31'h0001_0000;
    localparam logic [15:0]      HIGH_BASE  = 16'hD800;
    localparam logic [15:0]      LOW_BASE   = 16'hDC00;

    // decoder state carried between bytes
    typedef struct packed {
        logic [2:0]       exp_len;   // 0: no open sequence
        logic [2:0]       seen;
        logic [ACC_W-1:0] acc;
        logic             failed;
    } t_dec_state;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_status;
        logic        string_ok;
        logic        run_last;
    } t_result;

    // everything one byte produces
    typedef struct packed {
        logic [1:0]        cnt;
        t_result [2:0]     slot;
    } t_step_res;

    // sequence length from a lead byte; 0 for an ASCII byte or anything that cannot lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        casez (b)
            8'b110?_????: len = 3'd2;
            8'b1110_????: len = 3'd3;
            8'b1111_0???: len = 3'd4;
            8'b1111_10??: len = 3'd5;
            8'b1111_110?: len = 3'd6;
            default:      len = 3'd0;
        endcase
        return len;
    endfunction

    // keeps 5*len+1 bits of the accumulator
    function automatic logic [ACC_W-1:0] len_mask(input logic [2:0] len);
        logic [ACC_W-1:0] m;
        case (len)
            3'd2:    m = 31'h0000_07FF;
            3'd3:    m = 31'h0000_FFFF;
            3'd4:    m = 31'h001F_FFFF;
            3'd5:    m = 31'h03FF_FFFF;
            3'd6:    m = 31'h7FFF_FFFF;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

/* sv/u8u16_in_if.sv */
// Input channel of the decoder: one UTF-8 byte and its end-of-string flag.
// No dependencies.
interface u8u16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

/* sv/u8u16_out_if.sv */
// Output channel of the decoder: one UTF-16 code unit or status item.
// No dependencies.
interface u8u16_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        is_status;
    logic        string_ok;
    logic        run_last;

    modport source (output valid, output code_unit, output is_status,
                    output string_ok, output run_last, input ready);
    modport sink   (input valid, input code_unit, input is_status,
                    input string_ok, input run_last, output ready);
endinterface

/* sv/u8u16_step.sv */
// Combinational decode of one byte: next decoder state and up to three results.
// Depends on u8u16_pkg.
module u8u16_step (
    input  u8u16_pkg::t_dec_state i_state,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output u8u16_pkg::t_dec_state o_state,
    output u8u16_pkg::t_step_res  o_res
);
    import u8u16_pkg::*;

    logic [2:0]       len;
    logic [ACC_W-1:0] acc_sh;
    logic [ACC_W-1:0] val;
    logic [2:0]       seen_n;
    logic [20:0]      supp;
    logic             err;
    logic [1:0]       n_units;
    logic [15:0]      unit0;
    logic [15:0]      unit1;
    logic             ok;
    logic [1:0]       total;
    t_dec_state       st;

    assign len    = lead_len(i_byte);
    assign acc_sh = {i_state.acc[ACC_W-7:0], i_byte[5:0]};
    assign seen_n = i_state.seen + 3'd1;
    assign val    = acc_sh & len_mask(i_state.exp_len);
    assign supp   = val[20:0] - SUPP_BASE[20:0];

    always_comb begin
        st      = i_state;
        err     = 1'b0;
        n_units = 2'd0;
        unit0   = '0;
        unit1   = '0;
        if (!i_state.failed) begin
            if (i_state.exp_len == 3'd0) begin
                if (!i_byte[7]) begin
                    n_units = 2'd1;
                    unit0   = {8'h00, i_byte};
                end else if (len != 3'd0) begin
                    st.exp_len = len;
                    st.seen    = 3'd1;
                    st.acc     = {{(ACC_W-8){1'b0}}, i_byte};
                end else begin
                    err = 1'b1;
                end
            end else if (i_byte[7:6] != 2'b10) begin
                err = 1'b1;
            end else if (seen_n == i_state.exp_len) begin
                st.exp_len = 3'd0;
                st.seen    = 3'd0;
                st.acc     = '0;
                if ((val >= SURR_LO && val <= SURR_HI) || val > MAX_SCALAR) begin
                    err = 1'b1;
                end else if (val < SUPP_BASE) begin
                    n_units = 2'd1;
                    unit0   = val[15:0];
                end else begin
                    n_units = 2'd2;
                    unit0   = HIGH_BASE + {6'd0, supp[19:10]};
                    unit1   = LOW_BASE + {6'd0, supp[9:0]};
                end
            end else begin
                st.seen = seen_n;
                st.acc  = acc_sh;
            end
        end
        if (err) begin
            st        = '0;
            st.failed = 1'b1;
        end
    end

    assign ok = !st.failed && (st.exp_len == 3'd0);

    always_comb begin
        o_res = '0;
        o_res.slot[0].code_unit = unit0;
        o_res.slot[1].code_unit = unit1;
        total = n_units;
        if (i_last) begin
            o_res.slot[n_units]           = '0;
            o_res.slot[n_units].is_status = 1'b1;
            o_res.slot[n_units].string_ok = ok;
            total = n_units + 2'd1;
        end
        o_res.cnt = total;
        if (total != 2'd0) begin
            o_res.slot[total - 2'd1].run_last = 1'b1;
        end
        o_state = i_last ? '0 : st;
    end

endmodule

/* sv/utf8_to_utf16_decoder.sv */
// UTF-8 to UTF-16 decoder. One byte is decoded in the cycle it is accepted and its
// results (none, one or two code units, plus a status item on the last byte of a
// string) go into a three-entry result register that drains one item per cycle
// while the output is ready. A byte is accepted every cycle while the output is ready
// and each byte yields at most one result; a byte that yields more results holds the
// input, since the next byte is taken only once the result register is down to its
// final item being taken. Overlong forms are passed; after an error the rest of the
// string is dropped and its status item reports failure.
`include "utf8_to_utf16_decoder_defines.svh"

module utf8_to_utf16_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    u8u16_in_if.sink     i_in,
    u8u16_out_if.source  o_out
);
    import u8u16_pkg::*;

    t_dec_state    r_st;
    t_dec_state    n_st;
    t_result [2:0] r_slot;
    t_result [2:0] n_slot;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;

    t_dec_state    step_st;
    t_step_res     step_res;
    logic          in_fire;
    logic          pop;

    u8u16_step u_step (
        .i_state (r_st),
        .i_byte  (i_in.byte_in),
        .i_last  (i_in.last_byte),
        .o_state (step_st),
        .o_res   (step_res)
    );

    assign pop         = o_out.valid && o_out.ready;
    assign i_in.ready  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);
    assign in_fire     = i_in.valid && i_in.ready;

    assign o_out.valid     = (r_cnt != 2'd0);
    assign o_out.code_unit = r_slot[0].code_unit;
    assign o_out.is_status = r_slot[0].is_status;
    assign o_out.string_ok = r_slot[0].string_ok;
    assign o_out.run_last  = r_slot[0].run_last;

    always_comb begin
        n_st   = r_st;
        n_slot = r_slot;
        n_cnt  = r_cnt;
        if (in_fire) begin
            n_st   = step_st;
            n_slot = step_res.slot;
            n_cnt  = step_res.cnt;
        end else if (pop) begin
            n_slot[0] = r_slot[1];
            n_slot[1] = r_slot[2];
            n_cnt     = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= '0;
            r_cnt <= 2'd0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    `U8U16_ASSERT(a_status_ends_byte, i_clk, i_rst_n, (o_out.valid && o_out.is_status) |-> o_out.run_last, "status item not last of its byte")
    `U8U16_ASSERT(a_unit_not_ok, i_clk, i_rst_n, (o_out.valid && !o_out.is_status) |-> !o_out.string_ok, "code unit carries string_ok")
    `U8U16_ASSERT(a_tail_is_last, i_clk, i_rst_n, (o_out.valid && r_cnt == 2'd1) |-> o_out.run_last, "final buffered item lacks run_last")
    `U8U16_ASSERT(a_end_clears, i_clk, i_rst_n, (in_fire && i_in.last_byte) |=> (r_st.exp_len == 3'd0 && !r_st.failed && r_st.acc == '0), "state not cleared after last byte")
    `U8U16_ASSERT_ALWAYS(a_seq_count, i_clk, (r_st.exp_len != 3'd0) |-> (r_st.seen != 3'd0 && r_st.seen < r_st.exp_len && !r_st.failed), "open sequence count out of range")

endmodule
